/* src/assert_macros.svh */
// Assertion macros for the RTL of the block decoder.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* src/ps_adb_pkg.sv */
// Package of the ADPCM block decoder: shared types, constants, coefficient tables.
// No dependencies; used by every module of the block by scoped names.
package ps_adb_pkg;

    localparam logic [11:0] ILV_RESET = 12'd1;
    localparam logic [11:0] MAX_ILV   = 12'd2048;
    localparam logic [3:0]  MAX_SHIFT = 4'd12;
    localparam logic [3:0]  MAX_FILT  = 4'd4;
    localparam logic [4:0]  LAST_IDX  = 5'd27;

    localparam logic signed [20:0] SAT_MAX = 21'sd32767;
    localparam logic signed [20:0] SAT_MIN = -21'sd32768;

    // Classified block, front to back
    typedef struct packed {
        logic [3:0]   shamt;
        logic [2:0]   filt;
        logic         chan;
        logic         pair;
        logic [15:0]  base;
        logic [111:0] nibbles;
    } desc_t;

    // One decoded sample word
    typedef struct packed {
        logic signed [15:0] sample;
        logic               chan;
        logic [15:0]        pos;
        logic               last;
        logic               pair;
    } result_t;

    // Descriptor queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // First predictor tap
    function automatic logic signed [7:0] coef1(input logic [2:0] f);
        logic signed [7:0] c;
        unique case (f)
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            3'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    // Second predictor tap
    function automatic logic signed [7:0] coef2(input logic [2:0] f);
        logic signed [7:0] c;
        unique case (f)
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            3'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

/* src/ps_adpcm_block_decoder_unit.sv */
// Top level of the PS ADPCM block decoder.
// Depends on ps_adb_pkg, ps_adb_front, ps_adb_queue, ps_adb_back, assert_macros.svh.
//
// Usage:
//   Input channel: present one 16-byte block on block_header, block_flags and the two
//   nibble halves; it is taken at a clock edge with push high and full low. block_flags
//   is carried on the port but not decoded.
//   Result channel: while empty is low the oldest sample word is on sample, channel,
//   buffer_position, last_of_block and pair_complete; pop takes it.
//   Config: cfg_we writes cfg_data into the interleave register at the clock edge.
//   Throughput: one sample per cycle while the result buffer has room, 28 samples per
//   block, set by the two-tap predictor recurrence in the back end, where each sample
//   needs the one before it. The first sample of a block passes the block queue and
//   then the result buffer.
//   A two-entry block queue holds the block being decoded and one more, so one further
//   block can be taken while one decodes.
//   When the receiver stalls, a two-word result buffer fills and the predictor holds;
//   full rises once the block queue fills up. Nothing is dropped.
//   Reset: histories zero, left channel active, run position zero, interleave one,
//   all queues empty.
`include "assert_macros.svh"

module ps_adpcm_block_decoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [11:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         block_header,
    input  logic [7:0]         block_flags,
    input  logic [55:0]        nibbles_first_half,
    input  logic [55:0]        nibbles_second_half,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] sample,
    output logic               channel,
    output logic [15:0]        buffer_position,
    output logic               last_of_block,
    output logic               pair_complete
);

    ps_adb_pkg::q_status_t q_status;
    ps_adb_pkg::desc_t     desc_in;
    ps_adb_pkg::desc_t     desc_head;
    ps_adb_pkg::result_t   res;
    logic                  q_push;
    logic                  back_pop;

    // Front: classify and count runs
    ps_adb_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_data            (cfg_data),
        .push                (push),
        .block_header        (block_header),
        .nibbles_first_half  (nibbles_first_half),
        .nibbles_second_half (nibbles_second_half),
        .q_status            (q_status),
        .q_push              (q_push),
        .desc                (desc_in)
    );

    // Block queue
    ps_adb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (desc_in),
        .rd_en   (back_pop),
        .rd_data (desc_head),
        .status  (q_status)
    );

    // Back: sample decode
    ps_adb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (desc_head),
        .q_status  (q_status),
        .head_pop  (back_pop),
        .res       (res),
        .res_empty (empty),
        .res_pop   (pop)
    );

    assign full            = q_status.full;
    assign sample          = res.sample;
    assign channel         = res.chan;
    assign buffer_position = res.pos;
    assign last_of_block   = res.last;
    assign pair_complete   = res.pair;

    // Checks
    `ASSERT_IMPLY(a_pair_on_last, clk, rst_n, !empty && pair_complete, last_of_block)
    `ASSERT_IMPLY(a_pair_right, clk, rst_n, !empty && pair_complete, channel)
    `ASSERT_IMPLY(a_no_pop_empty_queue, clk, rst_n, q_status.empty, !back_pop)
    `ASSERT_NEXT(a_push_fills, clk, rst_n, q_push && !back_pop, !q_status.empty)

endmodule

/* src/ps_adb_front.sv */
// Front end: config register, block classification, channel/run bookkeeping.
// Depends on ps_adb_pkg.
module ps_adb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [11:0]           cfg_data,
    input  logic                  push,
    input  logic [7:0]            block_header,
    input  logic [55:0]           nibbles_first_half,
    input  logic [55:0]           nibbles_second_half,
    input  ps_adb_pkg::q_status_t q_status,
    output logic                  q_push,
    output ps_adb_pkg::desc_t     desc
);

    logic [11:0] ilv_reg;
    logic [10:0] bir_reg;
    logic [10:0] bir_next;
    logic        chan_reg;
    logic        chan_next;

    logic [11:0] eff_ilv;
    logic        run_end;
    logic [3:0]  shift_code;
    logic [3:0]  filt_code;

    // Effective interleave: zero acts as one, clamp to the maximum
    always_comb
    begin
        priority if (ilv_reg == 12'd0)
            eff_ilv = 12'd1;
        else if (ilv_reg > ps_adb_pkg::MAX_ILV)
            eff_ilv = ps_adb_pkg::MAX_ILV;
        else
            eff_ilv = ilv_reg;
    end

    assign run_end    = ({1'b0, bir_reg} + 12'd1) >= eff_ilv;
    assign shift_code = block_header[3:0];
    assign filt_code  = block_header[7:4];
    assign q_push     = push && !q_status.full;

    // Classify the incoming block
    always_comb
    begin
        desc.shamt   = (shift_code > ps_adb_pkg::MAX_SHIFT) ? 4'd0
                                                            : ps_adb_pkg::MAX_SHIFT - shift_code;
        desc.filt    = (filt_code > ps_adb_pkg::MAX_FILT) ? 3'd0 : filt_code[2:0];
        desc.chan    = chan_reg;
        desc.pair    = run_end && chan_reg;
        // position base = block_in_run * 28
        desc.base    = {bir_reg, 5'b0} - {3'b0, bir_reg, 2'b0};
        desc.nibbles = {nibbles_second_half, nibbles_first_half};
    end

    // Run counter advances per accepted block; the active channel flips at the end of each run
    always_comb
    begin
        bir_next  = bir_reg;
        chan_next = chan_reg;
        if (q_push)
        begin
            if (run_end)
            begin
                bir_next  = 11'd0;
                chan_next = !chan_reg;
            end
            else
            begin
                bir_next = bir_reg + 11'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ilv_reg  <= ps_adb_pkg::ILV_RESET;
            bir_reg  <= 11'd0;
            chan_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ilv_reg <= cfg_data;
            bir_reg  <= bir_next;
            chan_reg <= chan_next;
        end
    end

endmodule

/* src/ps_adb_queue.sv */
// Two-entry descriptor queue between front and back end.
// Depends on ps_adb_pkg.
module ps_adb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  ps_adb_pkg::desc_t     wr_data,
    input  logic                  rd_en,
    output ps_adb_pkg::desc_t     rd_data,
    output ps_adb_pkg::q_status_t status
);

    ps_adb_pkg::desc_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign status.full  = (cnt_reg == 2'd2);
    assign status.empty = (cnt_reg == 2'd0);
    assign rd_data      = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 2'd1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* src/ps_adb_back.sv */
// Back end: serial predictor, one sample per cycle, per-channel history, result buffer.
// Stalls while the result buffer is full or the queue is empty. Depends on ps_adb_pkg.
module ps_adb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ps_adb_pkg::desc_t     head,
    input  ps_adb_pkg::q_status_t q_status,
    output logic                  head_pop,
    output ps_adb_pkg::result_t   res,
    output logic                  res_empty,
    input  logic                  res_pop
);

    logic [4:0]         idx_reg;
    logic signed [15:0] left_h0_reg;
    logic signed [15:0] left_h1_reg;
    logic signed [15:0] right_h0_reg;
    logic signed [15:0] right_h1_reg;

    ps_adb_pkg::result_t out_mem_reg [2];
    logic       out_wr_reg;
    logic       out_rd_reg;
    logic [1:0] out_cnt_reg;
    logic [1:0] out_cnt_next;

    logic                room;
    logic                fire;
    logic                last;
    logic                out_take;
    logic [3:0]          nib;
    logic signed [15:0]  h0;
    logic signed [15:0]  h1;
    logic signed [7:0]   f1;
    logic signed [7:0]   f2;
    logic signed [15:0]  scaled;
    logic signed [25:0]  acc;
    logic signed [19:0]  pred;
    logic signed [20:0]  sum;
    logic signed [15:0]  r;
    ps_adb_pkg::result_t word;

    assign room     = (out_cnt_reg != 2'd2);
    assign fire     = !q_status.empty && room;
    assign last     = (idx_reg == ps_adb_pkg::LAST_IDX);
    assign head_pop = fire && last;
    assign out_take = res_pop && !res_empty;

    // Predictor step
    always_comb
    begin
        nib    = head.nibbles[{idx_reg, 2'b00} +: 4];
        h0     = head.chan ? right_h0_reg : left_h0_reg;
        h1     = head.chan ? right_h1_reg : left_h1_reg;
        f1     = ps_adb_pkg::coef1(head.filt);
        f2     = ps_adb_pkg::coef2(head.filt);
        scaled = $signed({{12{nib[3]}}, nib}) <<< head.shamt;
        acc    = h0 * f1 + h1 * f2 + 26'sd32;
        pred   = acc[25:6];
        sum    = $signed({{5{scaled[15]}}, scaled}) + $signed({pred[19], pred});
        priority if (sum > ps_adb_pkg::SAT_MAX)
            r = 16'sh7FFF;
        else if (sum < ps_adb_pkg::SAT_MIN)
            r = -16'sh8000;
        else
            r = sum[15:0];
    end

    // Result word
    always_comb
    begin
        word.sample = r;
        word.chan   = head.chan;
        word.pos    = head.base + {11'b0, idx_reg};
        word.last   = last;
        word.pair   = head.pair && last;
    end

    // Result buffer occupancy
    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (fire && !out_take)
            out_cnt_next = out_cnt_reg + 2'd1;
        else if (out_take && !fire)
            out_cnt_next = out_cnt_reg - 2'd1;
    end

    assign res_empty = (out_cnt_reg == 2'd0);
    assign res       = out_mem_reg[out_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= 5'd0;
            left_h0_reg  <= 16'sd0;
            left_h1_reg  <= 16'sd0;
            right_h0_reg <= 16'sd0;
            right_h1_reg <= 16'sd0;
            out_wr_reg   <= 1'b0;
            out_rd_reg   <= 1'b0;
            out_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (fire)
            begin
                idx_reg <= last ? 5'd0 : idx_reg + 5'd1;
                if (head.chan)
                begin
                    right_h1_reg <= right_h0_reg;
                    right_h0_reg <= r;
                end
                else
                begin
                    left_h1_reg <= left_h0_reg;
                    left_h0_reg <= r;
                end
                out_wr_reg <= !out_wr_reg;
            end
            if (out_take)
                out_rd_reg <= !out_rd_reg;
            out_cnt_reg <= out_cnt_next;
        end
    end

    // Result storage, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
            out_mem_reg[out_wr_reg] <= word;
    end

endmodule
